// ===== hw/rtl/quick_find_label_table_assert.svh =====
// Assertion macros for the quick-find label table.
`ifndef QUICK_FIND_LABEL_TABLE_ASSERT_SVH
`define QUICK_FIND_LABEL_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF
`define QFLT_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define QFLT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define QFLT_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)
`define QFLT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hw/rtl/qflt_pkg.sv =====
// Shared types, constants and microcode ROM of the quick-find label table.
package qflt_pkg;

  localparam int KIND_W    = 2;
  localparam int LABEL_W   = 10;
  localparam int CNT_W     = 11;
  localparam int CFG_W     = 11;
  localparam int CFG_RESET = 1024;

  typedef enum logic [KIND_W-1:0] {
    KIND_UNION   = 2'd0,
    KIND_READ    = 2'd1,
    KIND_COMPACT = 2'd2
  } qflt_kind_e;

  typedef enum logic [3:0] {
    ST_INIT      = 4'd0,
    ST_IDLE      = 4'd1,
    ST_CHECK     = 4'd2,
    ST_READ_Q    = 4'd3,
    ST_COMPACT_Q = 4'd4,
    ST_UNION     = 4'd5,
    ST_SCAN      = 4'd6,
    ST_TAIL      = 4'd7,
    ST_COMPACT   = 4'd8,
    ST_CSWEEP    = 4'd9,
    ST_FINISH    = 4'd10,
    ST_FIN_WAIT  = 4'd11
  } qflt_step_e;

  typedef enum logic [1:0] {RD_NONE, RD_IN, RD_IDX} qflt_rd_e;
  typedef enum logic [1:0] {WR_NONE, WR_IDENT, WR_RELABEL} qflt_wr_e;
  typedef enum logic [1:0] {IDX_HOLD, IDX_CLR, IDX_INC} qflt_idx_e;
  typedef enum logic [1:0] {CNT_HOLD, CNT_SETS_DEC, CNT_LIVE_LOAD} qflt_cnt_e;

  typedef enum logic [3:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_NO_ACCEPT,
    JC_CHK_ERR,
    JC_IS_READ,
    JC_IS_COMPACT,
    JC_SCAN_MORE,
    JC_SWEEP_MORE,
    JC_OUT_FREE
  } qflt_jc_e;

  typedef struct packed {
    qflt_rd_e   rd;
    qflt_wr_e   wr;
    qflt_idx_e  idx;
    qflt_cnt_e  cnt;
    logic       in_ready;
    logic       latch_res;
    logic       load_out;
    qflt_jc_e   jc;
    qflt_step_e target;
  } qflt_ucode_t;

  typedef struct packed {
    logic accept;
    logic chk_err;
    logic is_read;
    logic is_compact;
    logic scan_more;
    logic sweep_more;
    logic out_free;
  } qflt_flags_t;

  // Control store: jump to target when the condition holds, else step on.
  function automatic qflt_ucode_t qflt_rom(qflt_step_e step);
    qflt_ucode_t w;
    w = '{rd: RD_NONE, wr: WR_NONE, idx: IDX_HOLD, cnt: CNT_HOLD, in_ready: 1'b0,
          latch_res: 1'b0, load_out: 1'b0, jc: JC_NEVER, target: ST_IDLE};
    case (step)
      ST_INIT: begin
        w.wr = WR_IDENT; w.idx = IDX_INC; w.jc = JC_SWEEP_MORE; w.target = ST_INIT;
      end
      ST_IDLE: begin
        w.rd = RD_IN; w.in_ready = 1'b1; w.jc = JC_NO_ACCEPT; w.target = ST_IDLE;
      end
      ST_CHECK: begin
        w.latch_res = 1'b1; w.jc = JC_CHK_ERR; w.target = ST_FINISH;
      end
      ST_READ_Q: begin
        w.jc = JC_IS_READ; w.target = ST_FINISH;
      end
      ST_COMPACT_Q: begin
        w.jc = JC_IS_COMPACT; w.target = ST_COMPACT;
      end
      ST_UNION: begin
        w.cnt = CNT_SETS_DEC; w.idx = IDX_CLR;
      end
      ST_SCAN: begin
        w.rd = RD_IDX; w.wr = WR_RELABEL; w.idx = IDX_INC;
        w.jc = JC_SCAN_MORE; w.target = ST_SCAN;
      end
      ST_TAIL: begin
        w.wr = WR_RELABEL; w.jc = JC_ALWAYS; w.target = ST_FINISH;
      end
      ST_COMPACT: begin
        w.cnt = CNT_LIVE_LOAD; w.idx = IDX_CLR;
      end
      ST_CSWEEP: begin
        w.wr = WR_IDENT; w.idx = IDX_INC; w.jc = JC_SWEEP_MORE; w.target = ST_CSWEEP;
      end
      ST_FINISH: begin
        w.load_out = 1'b1; w.jc = JC_OUT_FREE; w.target = ST_IDLE;
      end
      ST_FIN_WAIT: begin
        w.jc = JC_ALWAYS; w.target = ST_FINISH;
      end
      default: begin
        w.jc = JC_ALWAYS; w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/qflt_in_if.sv =====
// Item channel of the quick-find label table.
interface qflt_in_if;
  import qflt_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [LABEL_W-1:0] first_label;
  logic [LABEL_W-1:0] second_label;

  modport source (output valid, kind, first_label, second_label, input ready);
  modport sink (input valid, kind, first_label, second_label, output ready);
endinterface

// ===== hw/rtl/qflt_out_if.sv =====
// Result channel of the quick-find label table.
interface qflt_out_if;
  import qflt_pkg::*;

  logic               valid;
  logic               ready;
  logic [LABEL_W-1:0] read_value;
  logic [CNT_W-1:0]   set_count;
  logic               error;

  modport source (output valid, read_value, set_count, error, input ready);
  modport sink (input valid, read_value, set_count, error, output ready);
endinterface

// ===== hw/rtl/qflt_seq.sv =====
// Microcode sequencer: step counter, control store and conditional jumps.
module qflt_seq (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  restart_i,
  input  qflt_pkg::qflt_flags_t flags_i,
  output qflt_pkg::qflt_ucode_t ucode_o
);
  import qflt_pkg::*;

  qflt_step_e  upc_q, upc_d;
  qflt_ucode_t ucode;
  logic        jump;

  assign ucode   = qflt_rom(upc_q);
  assign ucode_o = ucode;

  always_comb begin
    case (ucode.jc)
      JC_NEVER:      jump = 1'b0;
      JC_ALWAYS:     jump = 1'b1;
      JC_NO_ACCEPT:  jump = !flags_i.accept;
      JC_CHK_ERR:    jump = flags_i.chk_err;
      JC_IS_READ:    jump = flags_i.is_read;
      JC_IS_COMPACT: jump = flags_i.is_compact;
      JC_SCAN_MORE:  jump = flags_i.scan_more;
      JC_SWEEP_MORE: jump = flags_i.sweep_more;
      JC_OUT_FREE:   jump = flags_i.out_free;
      default:       jump = 1'b0;
    endcase

    if (restart_i) begin
      upc_d = ST_INIT;
    end else if (jump) begin
      upc_d = ucode.target;
    end else begin
      upc_d = qflt_step_e'(upc_q + 4'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= ST_INIT;
    end else begin
      upc_q <= upc_d;
    end
  end
endmodule

// ===== hw/rtl/quick_find_label_table.sv =====
// Quick-find union-find label table. One item is taken at a time, and each gives one
// result. The labels sit in a single-port-read, single-port-write memory of
// MAX_ELEMENTS entries, and every pass over it moves one entry per cycle. An error
// item goes from the check straight to the finish step, a read passes the read step too,
// a union scans the live labels, and a compact sweeps all entries; then the result is registered.
// The next item is accepted while the last result still waits to be taken. After reset,
// and after each initial_size write, a clearing pass loads identity labels into all
// MAX_ELEMENTS entries, and no item is accepted during it.
`include "quick_find_label_table_assert.svh"

module quick_find_label_table #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [qflt_pkg::CFG_W-1:0] cfg_wdata_i,
  qflt_in_if.sink                   in_i,
  qflt_out_if.source                out_o
);
  import qflt_pkg::*;

  localparam int LW       = $clog2(MAX_ELEMENTS);
  localparam int CW       = $clog2(MAX_ELEMENTS + 1);
  localparam int CMP_W    = (CW > LABEL_W) ? CW : LABEL_W;
  localparam int VW       = (CW > CFG_W) ? CW : CFG_W;
  localparam int RST_SIZE = (CFG_RESET < MAX_ELEMENTS) ? CFG_RESET : MAX_ELEMENTS;

  qflt_ucode_t ucode;
  qflt_flags_t flags;

  logic [CW-1:0]      idx_q, live_q, sets_q, size_d;
  logic [KIND_W-1:0]  kind_q;
  logic [LABEL_W-1:0] a_q, b_q, rv_q, rv_d;
  logic               err_q, chk_err;
  logic [LW-1:0]      mem_q [MAX_ELEMENTS];
  logic [LW-1:0]      rdata_q, rd_addr_q;
  logic               mem_re, mem_we;
  logic [LW-1:0]      mem_raddr, mem_waddr, mem_wdata;
  logic [VW-1:0]      cfg_ext;
  logic               accept, out_free, load_out, out_valid_q;
  logic [LABEL_W-1:0] out_value_q;
  logic [CNT_W-1:0]   out_count_q;
  logic               out_err_q;

  qflt_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_we_i),
    .flags_i   (flags),
    .ucode_o   (ucode)
  );

  assign in_i.ready = ucode.in_ready;
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign load_out   = ucode.load_out && out_free;

  // Size clamp: zero reads as one, anything above the depth as the depth.
  assign cfg_ext = VW'(cfg_wdata_i);
  always_comb begin
    if (cfg_ext == '0) begin
      size_d = CW'(1);
    end else if (cfg_ext > VW'(MAX_ELEMENTS)) begin
      size_d = CW'(MAX_ELEMENTS);
    end else begin
      size_d = CW'(cfg_ext);
    end
  end

  // Precondition check; rdata_q holds labels[second] for a union, labels[first] for a read.
  always_comb begin
    case (kind_q)
      KIND_UNION: chk_err = (a_q == b_q) || (CMP_W'(a_q) >= CMP_W'(live_q)) ||
                            (CMP_W'(b_q) >= CMP_W'(live_q)) ||
                            (CMP_W'(rdata_q) != CMP_W'(b_q)) || (sets_q == '0);
      KIND_READ:    chk_err = CMP_W'(a_q) >= CMP_W'(live_q);
      KIND_COMPACT: chk_err = 1'b0;
      default:      chk_err = 1'b1;
    endcase
    rv_d = ((kind_q == KIND_READ) && !chk_err) ? LABEL_W'(rdata_q) : '0;
  end

  always_comb begin
    flags.accept     = accept;
    flags.chk_err    = chk_err;
    flags.is_read    = kind_q == KIND_READ;
    flags.is_compact = kind_q == KIND_COMPACT;
    flags.scan_more  = (idx_q + 1'b1) < live_q;
    flags.sweep_more = idx_q != CW'(MAX_ELEMENTS - 1);
    flags.out_free   = out_free;
  end

  // Memory port selection
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = idx_q[LW-1:0];
    case (ucode.rd)
      RD_IN: begin
        mem_re    = 1'b1;
        mem_raddr = (in_i.kind == KIND_READ) ? LW'(in_i.first_label)
                                             : LW'(in_i.second_label);
      end
      RD_IDX:  mem_re = 1'b1;
      default: mem_re = 1'b0;
    endcase

    mem_we    = 1'b0;
    mem_waddr = idx_q[LW-1:0];
    mem_wdata = idx_q[LW-1:0];
    case (ucode.wr)
      WR_IDENT: mem_we = 1'b1;
      WR_RELABEL: begin
        // on the first scan beat rdata_q is labels[second] == second, never a match
        mem_we    = rdata_q == LW'(a_q);
        mem_waddr = rd_addr_q;
        mem_wdata = LW'(b_q);
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q   <= mem_q[mem_raddr];
      rd_addr_q <= mem_raddr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      live_q <= CW'(RST_SIZE);
      sets_q <= CW'(RST_SIZE);
    end else if (cfg_we_i) begin
      idx_q  <= '0;
      live_q <= size_d;
      sets_q <= size_d;
    end else begin
      case (ucode.idx)
        IDX_CLR: idx_q <= '0;
        IDX_INC: idx_q <= idx_q + 1'b1;
        default: idx_q <= idx_q;
      endcase
      case (ucode.cnt)
        CNT_SETS_DEC:  sets_q <= sets_q - 1'b1;
        CNT_LIVE_LOAD: live_q <= sets_q;
        default: begin
          sets_q <= sets_q;
          live_q <= live_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= in_i.kind;
      a_q    <= in_i.first_label;
      b_q    <= in_i.second_label;
    end
    if (ucode.latch_res) begin
      err_q <= chk_err;
      rv_q  <= rv_d;
    end
    if (load_out) begin
      out_value_q <= rv_q;
      out_count_q <= CNT_W'(sets_q);
      out_err_q   <= err_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_value = out_value_q;
  assign out_o.set_count  = out_count_q;
  assign out_o.error      = out_err_q;

  `QFLT_ASSERT_NEXT(a_one_item, clk_i, rst_ni, accept, !in_i.ready, "second item taken while busy")
  `QFLT_ASSERT_IMPL(a_sets_le_live, clk_i, rst_ni, 1'b1, sets_q <= live_q, "set count above live length")
  `QFLT_ASSERT_IMPL(a_err_zero, clk_i, rst_ni, out_o.valid && out_o.error, out_o.read_value == '0, "error beat carries a label")
endmodule

// ===== dv/quick_find_label_table_checker.sv =====
// Checker for the quick-find label table: tracks table state from observed beats, scores results.
`timescale 1ns / 1ps
module quick_find_label_table_checker #(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [qflt_pkg::CFG_W-1:0] cfg_wdata_i,
  qflt_in_if                         item_mon,
  qflt_out_if                        result_mon,
  output int                         fail_count_o
);
  import qflt_pkg::*;

  typedef struct packed {
    logic [LABEL_W-1:0] read_value;
    logic [CNT_W-1:0]   set_count;
    logic               error;
  } label_result_t;

  logic [LABEL_W-1:0] label_mem [MAX_ELEMENTS];
  logic [CNT_W-1:0]   live_len;
  logic [CNT_W-1:0]   sets_rem;
  label_result_t      pending_results [$];
  int                 mismatch_cnt;

  function automatic logic [CNT_W-1:0] clamp_size(logic [CFG_W-1:0] v);
    if (v == '0) return CNT_W'(1);
    if (int'(v) > MAX_ELEMENTS) return CNT_W'(MAX_ELEMENTS);
    return CNT_W'(v);
  endfunction

  task automatic load_identity(logic [CNT_W-1:0] n);
    for (int i = 0; i < MAX_ELEMENTS; i++) label_mem[i] = LABEL_W'(i);
    live_len = n;
    sets_rem = n;
  endtask

  task automatic step_label_table(input logic [KIND_W-1:0] kind, input logic [LABEL_W-1:0] a,
                                  input logic [LABEL_W-1:0] b, output label_result_t res);
    res = '0;
    case (kind)
      KIND_UNION: begin
        if (a == b || CNT_W'(a) >= live_len || CNT_W'(b) >= live_len ||
            label_mem[b] != b || sets_rem == '0) begin
          res.error = 1'b1;
        end else begin
          sets_rem = sets_rem - 1'b1;
          for (int i = 0; i < MAX_ELEMENTS; i++) begin
            if (i < int'(live_len) && label_mem[i] == a) label_mem[i] = b;
          end
        end
      end
      KIND_READ: begin
        if (CNT_W'(a) >= live_len) res.error = 1'b1;
        else res.read_value = label_mem[a];
      end
      KIND_COMPACT: begin
        load_identity(sets_rem);
      end
      default: res.error = 1'b1;
    endcase
    res.set_count = sets_rem;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    label_result_t want;
    label_result_t got;
    if (!rst_ni) begin
      load_identity(clamp_size(CFG_W'(CFG_RESET)));
      pending_results.delete();
      mismatch_cnt = 0;
    end else begin
      if (cfg_we_i) load_identity(clamp_size(cfg_wdata_i));
      if (item_mon.valid && item_mon.ready) begin
        step_label_table(item_mon.kind, item_mon.first_label, item_mon.second_label, want);
        pending_results.push_back(want);
      end
      if (result_mon.valid && result_mon.ready) begin
        got.read_value = result_mon.read_value;
        got.set_count  = result_mon.set_count;
        got.error      = result_mon.error;
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing pending: read_value %0d set_count %0d error %0d",
                   $time, got.read_value, got.set_count, got.error);
          mismatch_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (got.read_value !== want.read_value) begin
            $display("%0t: read_value expected %0d actual %0d",
                     $time, want.read_value, got.read_value);
            mismatch_cnt++;
          end
          if (got.set_count !== want.set_count) begin
            $display("%0t: set_count expected %0d actual %0d",
                     $time, want.set_count, got.set_count);
            mismatch_cnt++;
          end
          if (got.error !== want.error) begin
            $display("%0t: error expected %0d actual %0d", $time, want.error, got.error);
            mismatch_cnt++;
          end
        end
      end
    end
    // anything still pending at the end counts against the run
    fail_count_o = mismatch_cnt + int'(pending_results.size());
  end

endmodule

// ===== dv/quick_find_label_table_tb.sv =====
// Testbench top for the quick-find label table: stimulus, register writes and verdict.
`timescale 1ns / 1ps
module quick_find_label_table_tb;
  import qflt_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int HOLD_CYCLES = 3000;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int TAIL_CYCLES = 64;
  localparam logic [KIND_W-1:0] KIND_ILLEGAL = 2'd3;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  qflt_in_if  item_if ();
  qflt_out_if result_if ();

  int fail_count;
  int sent_cnt  = 0;
  int taken_cnt = 0;
  bit calm      = 1'b0;
  bit hold_req  = 1'b0;
  bit offering  = 1'b0;

  // coarse mirror used only to steer stimulus toward legal unions
  int sh_live;
  int sh_sets;
  int sh_roots;
  bit sh_gone [TABLE_DEPTH];

  quick_find_label_table #(
    .MAX_ELEMENTS(TABLE_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (item_if),
    .out_o      (result_if)
  );

  quick_find_label_table_checker #(
    .MAX_ELEMENTS(TABLE_DEPTH)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_mon    (item_if),
    .result_mon  (result_if),
    .fail_count_o(fail_count)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (result_if.valid && result_if.ready) taken_cnt <= taken_cnt + 1;
  end

  function automatic int clamp_cfg(int v);
    return (v < 1) ? 1 : (v > TABLE_DEPTH) ? TABLE_DEPTH : v;
  endfunction

  task automatic shadow_load(int n);
    foreach (sh_gone[i]) sh_gone[i] = 1'b0;
    sh_live  = n;
    sh_sets  = n;
    sh_roots = n;
  endtask

  function automatic int pick_root(int skip);
    int start;
    int idx;
    start = $urandom_range(0, sh_live - 1);
    for (int i = 0; i < sh_live; i++) begin
      idx = (start + i) % sh_live;
      if (!sh_gone[idx] && idx != skip) return idx;
    end
    return 0;
  endfunction

  task automatic shadow_note(logic [KIND_W-1:0] kind, int a, int b);
    case (kind)
      KIND_UNION: begin
        if (a != b && a < sh_live && b < sh_live && !sh_gone[b] && sh_sets > 0) begin
          sh_sets--;
          if (!sh_gone[a]) begin
            sh_gone[a] = 1'b1;
            sh_roots--;
          end
        end
      end
      KIND_COMPACT: shadow_load(sh_sets);
      default: ;
    endcase
  endtask

  task automatic send_item(logic [KIND_W-1:0] kind, logic [LABEL_W-1:0] a,
                           logic [LABEL_W-1:0] b);
    if (!calm && $urandom_range(0, 3) == 0) begin
      if (offering) item_if.valid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    item_if.valid        <= 1'b1;
    item_if.kind         <= kind;
    item_if.first_label  <= a;
    item_if.second_label <= b;
    offering = 1'b1;
    do @(posedge clk_i); while (!item_if.ready);
    sent_cnt++;
    shadow_note(kind, int'(a), int'(b));
  endtask

  task automatic drain_results();
    if (offering) item_if.valid <= 1'b0;
    offering = 1'b0;
    while (taken_cnt < sent_cnt) @(posedge clk_i);
  endtask

  task automatic write_size(int v);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CFG_W'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_load(clamp_cfg(v));
  endtask

  task automatic random_item();
    int pick;
    logic [LABEL_W-1:0] a;
    logic [LABEL_W-1:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 70 && sh_roots >= 2 && sh_sets > 0) begin
      b = LABEL_W'(pick_root(-1));
      if (pick < 60) begin
        a = LABEL_W'(pick_root(int'(b)));
      end else begin
        // any live label, merged or not
        a = LABEL_W'($urandom_range(0, sh_live - 1));
        if (a == b) a = LABEL_W'(pick_root(int'(b)));
      end
      send_item(KIND_UNION, a, b);
    end else if (pick < 88) begin
      if (sh_live > 0 && $urandom_range(0, 4) != 0) a = LABEL_W'($urandom_range(0, sh_live - 1));
      else a = LABEL_W'($urandom);
      send_item(KIND_READ, a, LABEL_W'($urandom));
    end else if (pick < 91) begin
      send_item(KIND_COMPACT, LABEL_W'($urandom), LABEL_W'($urandom));
    end else begin
      a = LABEL_W'($urandom);
      b = LABEL_W'($urandom);
      case ($urandom_range(0, 2))
        0: send_item(KIND_ILLEGAL, a, b);
        1: send_item(KIND_UNION, a, b);
        default: send_item(KIND_UNION, a, a);
      endcase
    end
  endtask

  task automatic run_phase(int size, int items, bit squeeze, bit pause_mid);
    write_size(size);
    if (squeeze) hold_req = 1'b1;
    for (int n = 0; n < items; n++) begin
      if (pause_mid && n == items / 2) drain_results();
      // refill once merges run dry, so unions keep doing real work
      if (sh_roots < 2 && clamp_cfg(size) > 2 && $urandom_range(0, 2) == 0) write_size(size);
      random_item();
    end
  endtask

  initial begin : result_sink
    result_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        result_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        result_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        result_if.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    rst_ni                = 1'b0;
    cfg_we_i              = 1'b0;
    cfg_wdata_i           = '0;
    item_if.valid         = 1'b0;
    item_if.kind          = '0;
    item_if.first_label   = '0;
    item_if.second_label  = '0;
    shadow_load(TABLE_DEPTH);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full reset-size table
    send_item(KIND_READ, 10'd0, 10'd0);
    send_item(KIND_READ, 10'd1023, 10'd1023);
    send_item(KIND_UNION, 10'd1023, 10'd0);
    send_item(KIND_READ, 10'd1023, 10'd0);
    send_item(KIND_UNION, 10'd5, 10'd5);
    send_item(KIND_UNION, 10'd0, 10'd1023);     // 1023 is no longer a root
    send_item(KIND_ILLEGAL, 10'd1023, 10'd1023);
    send_item(KIND_UNION, 10'd0, 10'd1);
    send_item(KIND_READ, 10'd1023, 10'd0);
    send_item(KIND_COMPACT, 10'd0, 10'd0);      // live length drops to 1022
    send_item(KIND_READ, 10'd1022, 10'd0);
    send_item(KIND_READ, 10'd1021, 10'd0);
    send_item(KIND_UNION, 10'd1022, 10'd3);
    send_item(KIND_UNION, 10'd3, 10'd1022);

    // two elements: run the set count to zero, then compact to nothing
    write_size(2);
    send_item(KIND_UNION, 10'd0, 10'd1);
    send_item(KIND_UNION, 10'd0, 10'd1);
    send_item(KIND_UNION, 10'd0, 10'd1);
    send_item(KIND_COMPACT, 10'd0, 10'd0);
    send_item(KIND_READ, 10'd0, 10'd0);
    send_item(KIND_UNION, 10'd1, 10'd0);
    send_item(KIND_ILLEGAL, 10'd0, 10'd0);

    run_phase(2047, 40, 1'b0, 1'b0);
    run_phase(0, 20, 1'b0, 1'b0);
    run_phase(7, 60, 1'b0, 1'b0);
    run_phase(16, 80, 1'b1, 1'b0);
    run_phase(40, 100, 1'b0, 1'b1);
    run_phase(130, 60, 1'b0, 1'b0);
    run_phase(33, 60, 1'b0, 1'b0);
    run_phase(1024, 20, 1'b0, 1'b0);
    run_phase(2, 20, 1'b0, 1'b0);
    run_phase(3, 20, 1'b0, 1'b0);
    calm = 1'b1;
    run_phase(64, 100, 1'b0, 1'b0);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
